// ----- rtl/core/rpba_pkg.sv -----
package rpba_pkg;

	// Default pool sizes; index 0 of each pool is reserved to mean "none".
	localparam int NUM_PACKETS_DEF = 1023;
	localparam int NUM_BUFFERS_DEF = 1023;

	// Port widths fixed by the interface.
	localparam int OP_W     = 2;
	localparam int IDX_W    = 10;
	localparam int STATUS_W = 2;
	localparam int REFS_W   = 16;

	localparam logic [REFS_W-1:0] MAX_REFS_RESET = 16'd255;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLONE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_PKT  = 2'd1,
		ST_NO_BUF  = 2'd2,
		ST_REF_LIM = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_CLEAR  = 2'd0,
		FSM_IDLE   = 2'd1,
		FSM_LOOKUP = 2'd2,
		FSM_WRITE  = 2'd3
	} fsm_t;

endpackage

// ----- rtl/core/rpba_ram.sv -----
module rpba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; read data holds while rd_en is low.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/refcounted_packet_buffer_allocator_top.sv -----
// Channel   Direction  Handshake            Word
// input     in         in_valid/in_ready    operation, packet_index
// result    out        out_valid/out_ready  result_packet, buffer_index, status,
//                                           buffer_released, packets_in_use, buffers_in_use
// config    in         cfg_wr_en            cfg_wr_data (max_refs)
//
// Allocate goes from acceptance straight to write-back; free and clone first pass a lookup
// state, as the reference count is read at the buffer that the descriptor table returns.
// One operation is in flight; the next is accepted the cycle after write-back.
// After reset a clearing pass zeroes all NUM_PACKETS+1 descriptor table entries, with
// in_ready low; configuration writes are taken during it.
// A result that is not taken stalls the write-back stage, which holds all read data.
module refcounted_packet_buffer_allocator_top #(
	parameter int NUM_PACKETS = rpba_pkg::NUM_PACKETS_DEF,
	parameter int NUM_BUFFERS = rpba_pkg::NUM_BUFFERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rpba_pkg::REFS_W-1:0]     cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rpba_pkg::OP_W-1:0]       operation,
	input  logic [rpba_pkg::IDX_W-1:0]      packet_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rpba_pkg::IDX_W-1:0]      result_packet,
	output logic [rpba_pkg::IDX_W-1:0]      buffer_index,
	output logic [rpba_pkg::STATUS_W-1:0]   status,
	output logic                            buffer_released,
	output logic [rpba_pkg::IDX_W-1:0]      packets_in_use,
	output logic [rpba_pkg::IDX_W-1:0]      buffers_in_use
);

	localparam int PW  = $clog2(NUM_PACKETS + 1);
	localparam int BW  = $clog2(NUM_BUFFERS + 1);
	localparam int PSW = $clog2(NUM_PACKETS);
	localparam int BSW = $clog2(NUM_BUFFERS);
	localparam int RW  = rpba_pkg::REFS_W;

	rpba_pkg::fsm_t state_q, state_d;

	logic [PW-1:0] clr_q;
	logic [RW-1:0] max_refs_q;
	logic [PW-1:0] ptop_q, pmin_q, pcnt_q;
	logic [BW-1:0] btop_q, bmin_q, bcnt_q;

	rpba_pkg::op_t op_s1;
	logic [PW-1:0] pi_s1;
	logic          pi_ok_s1;
	logic          out_valid_q;

	logic in_acc, wb_fire;

	// Memory ports.
	logic          p2b_we, p2b_re;
	logic [PW-1:0] p2b_wa, p2b_ra;
	logic [BW-1:0] p2b_wd, p2b_rd;
	logic          rc_we, rc_re;
	logic [BW-1:0] rc_wa, rc_ra;
	logic [RW-1:0] rc_wd, rc_rd;
	logic           pstk_we, pstk_re;
	logic [PSW-1:0] pstk_wa, pstk_ra;
	logic [PW-1:0]  pstk_wd, pstk_rd;
	logic           bstk_we, bstk_re;
	logic [BSW-1:0] bstk_wa, bstk_ra;
	logic [BW-1:0]  bstk_wd, bstk_rd;

	// Write-back values.
	logic [PW-1:0] pk_new, res_d, ptop_d, pmin_d, pcnt_d;
	logic [BW-1:0] bf_new, buf_d, btop_d, bmin_d, bcnt_d;
	logic [RW-1:0] rc_dec;
	logic          pkt_ok, rel_d;
	rpba_pkg::status_t st_d;

	assign in_ready = (state_q == rpba_pkg::FSM_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign wb_fire  = (state_q == rpba_pkg::FSM_WRITE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Descriptor table: packet to buffer link, zero when the packet is free.
	rpba_ram #(.WIDTH(BW), .DEPTH(NUM_PACKETS + 1)) u_p2b (
		.clk(clk), .wr_en(p2b_we), .wr_addr(p2b_wa), .wr_data(p2b_wd),
		.rd_en(p2b_re), .rd_addr(p2b_ra), .rd_data(p2b_rd)
	);

	// Buffer reference counts; a count is only used after allocate has set it.
	rpba_ram #(.WIDTH(RW), .DEPTH(NUM_BUFFERS + 1)) u_rc (
		.clk(clk), .wr_en(rc_we), .wr_addr(rc_wa), .wr_data(rc_wd),
		.rd_en(rc_re), .rd_addr(rc_ra), .rd_data(rc_rd)
	);

	// Free packet stack; entries below the low-water mark are never written, and their reset contents are computed.
	rpba_ram #(.WIDTH(PW), .DEPTH(NUM_PACKETS)) u_pstk (
		.clk(clk), .wr_en(pstk_we), .wr_addr(pstk_wa), .wr_data(pstk_wd),
		.rd_en(pstk_re), .rd_addr(pstk_ra), .rd_data(pstk_rd)
	);

	// Free buffer stack, same scheme.
	rpba_ram #(.WIDTH(BW), .DEPTH(NUM_BUFFERS)) u_bstk (
		.clk(clk), .wr_en(bstk_we), .wr_addr(bstk_wa), .wr_data(bstk_wd),
		.rd_en(bstk_re), .rd_addr(bstk_ra), .rd_data(bstk_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rpba_pkg::FSM_CLEAR: begin
				if (clr_q == PW'(NUM_PACKETS)) begin
					state_d = rpba_pkg::FSM_IDLE;
				end
			end
			rpba_pkg::FSM_IDLE: begin
				if (in_acc) begin
					if (rpba_pkg::op_t'(operation) == rpba_pkg::OP_FREE ||
					    rpba_pkg::op_t'(operation) == rpba_pkg::OP_CLONE) begin
						state_d = rpba_pkg::FSM_LOOKUP;
					end else begin
						state_d = rpba_pkg::FSM_WRITE;
					end
				end
			end
			rpba_pkg::FSM_LOOKUP: begin
				state_d = rpba_pkg::FSM_WRITE;
			end
			rpba_pkg::FSM_WRITE: begin
				if (wb_fire) begin
					state_d = rpba_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = rpba_pkg::FSM_IDLE;
			end
		endcase
	end

	// Popped indices: memory at or above the low-water mark, else the reset contents N - i.
	always_comb begin
		pk_new = (ptop_q > pmin_q) ? pstk_rd : (PW'(NUM_PACKETS) - ptop_q + PW'(1));
		bf_new = (btop_q > bmin_q) ? bstk_rd : (BW'(NUM_BUFFERS) - btop_q + BW'(1));
		pkt_ok = pi_ok_s1 && (p2b_rd != '0);
		rc_dec = rc_rd - RW'(rc_rd != '0);
	end

	// Memory controls and write-back values.
	always_comb begin
		p2b_we = 1'b0; p2b_wa = '0; p2b_wd = '0;
		p2b_re = 1'b0; p2b_ra = PW'(packet_index);
		rc_we = 1'b0; rc_wa = p2b_rd; rc_wd = '0;
		rc_re = 1'b0; rc_ra = p2b_rd;
		pstk_we = 1'b0; pstk_wa = PSW'(ptop_q); pstk_wd = pi_s1;
		pstk_re = 1'b0; pstk_ra = PSW'(ptop_q - PW'(1));
		bstk_we = 1'b0; bstk_wa = BSW'(btop_q); bstk_wd = p2b_rd;
		bstk_re = 1'b0; bstk_ra = BSW'(btop_q - BW'(1));
		res_d = '0; buf_d = '0; st_d = rpba_pkg::ST_OK; rel_d = 1'b0;
		ptop_d = ptop_q; pmin_d = pmin_q; pcnt_d = pcnt_q;
		btop_d = btop_q; bmin_d = bmin_q; bcnt_d = bcnt_q;
		case (state_q)
			rpba_pkg::FSM_CLEAR: begin
				p2b_we = 1'b1;
				p2b_wa = clr_q;
			end
			rpba_pkg::FSM_IDLE: begin
				if (in_acc) begin
					case (rpba_pkg::op_t'(operation))
						rpba_pkg::OP_ALLOC: begin
							pstk_re = (ptop_q != '0);
							bstk_re = (btop_q != '0);
						end
						rpba_pkg::OP_FREE: begin
							p2b_re = (packet_index != '0) &&
							         (16'(packet_index) <= 16'(NUM_PACKETS));
						end
						rpba_pkg::OP_CLONE: begin
							pstk_re = (ptop_q != '0);
							p2b_re = (packet_index != '0) &&
							         (16'(packet_index) <= 16'(NUM_PACKETS));
						end
						default: begin
						end
					endcase
				end
			end
			rpba_pkg::FSM_LOOKUP: begin
				rc_re = 1'b1;
			end
			rpba_pkg::FSM_WRITE: begin
				case (op_s1)
					rpba_pkg::OP_ALLOC: begin
						if (ptop_q == '0) begin
							st_d = rpba_pkg::ST_NO_PKT;
						end else if (btop_q == '0) begin
							st_d = rpba_pkg::ST_NO_BUF;
						end else begin
							res_d = pk_new;
							buf_d = bf_new;
							p2b_we = wb_fire; p2b_wa = pk_new; p2b_wd = bf_new;
							rc_we = wb_fire; rc_wa = bf_new; rc_wd = RW'(1);
							ptop_d = ptop_q - PW'(1);
							btop_d = btop_q - BW'(1);
							pmin_d = (ptop_d < pmin_q) ? ptop_d : pmin_q;
							bmin_d = (btop_d < bmin_q) ? btop_d : bmin_q;
							pcnt_d = pcnt_q + PW'(1);
							bcnt_d = bcnt_q + BW'(1);
						end
					end
					rpba_pkg::OP_FREE: begin
						if (pkt_ok) begin
							buf_d = p2b_rd;
							p2b_we = wb_fire; p2b_wa = pi_s1; p2b_wd = '0;
							rc_we = wb_fire; rc_wd = rc_dec;
							if (ptop_q < PW'(NUM_PACKETS)) begin
								pstk_we = wb_fire;
								ptop_d = ptop_q + PW'(1);
							end
							if (pcnt_q != '0) begin
								pcnt_d = pcnt_q - PW'(1);
							end
							if (rc_dec == '0) begin
								rel_d = 1'b1;
								if (btop_q < BW'(NUM_BUFFERS)) begin
									bstk_we = wb_fire;
									btop_d = btop_q + BW'(1);
								end
								if (bcnt_q != '0) begin
									bcnt_d = bcnt_q - BW'(1);
								end
							end
						end
					end
					rpba_pkg::OP_CLONE: begin
						if (ptop_q == '0) begin
							st_d = rpba_pkg::ST_NO_PKT;
						end else if (!pkt_ok) begin
							st_d = rpba_pkg::ST_NO_BUF;
						end else if (rc_rd >= max_refs_q) begin
							st_d = rpba_pkg::ST_REF_LIM;
						end else begin
							res_d = pk_new;
							buf_d = p2b_rd;
							p2b_we = wb_fire; p2b_wa = pk_new; p2b_wd = p2b_rd;
							rc_we = wb_fire; rc_wd = rc_rd + RW'(1);
							ptop_d = ptop_q - PW'(1);
							pmin_d = (ptop_d < pmin_q) ? ptop_d : pmin_q;
							pcnt_d = pcnt_q + PW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpba_pkg::FSM_CLEAR;
			clr_q       <= '0;
			max_refs_q  <= rpba_pkg::MAX_REFS_RESET;
			ptop_q      <= PW'(NUM_PACKETS);
			pmin_q      <= PW'(NUM_PACKETS);
			pcnt_q      <= '0;
			btop_q      <= BW'(NUM_BUFFERS);
			bmin_q      <= BW'(NUM_BUFFERS);
			bcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rpba_pkg::FSM_CLEAR) begin
				clr_q <= clr_q + PW'(1);
			end
			if (cfg_wr_en) begin
				max_refs_q <= cfg_wr_data;
			end
			if (wb_fire) begin
				ptop_q <= ptop_d;
				pmin_q <= pmin_d;
				pcnt_q <= pcnt_d;
				btop_q <= btop_d;
				bmin_q <= bmin_d;
				bcnt_q <= bcnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operation capture and result word registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= rpba_pkg::op_t'(operation);
			pi_s1    <= PW'(packet_index);
			pi_ok_s1 <= (packet_index != '0) && (16'(packet_index) <= 16'(NUM_PACKETS));
		end
		if (wb_fire) begin
			result_packet   <= rpba_pkg::IDX_W'(res_d);
			buffer_index    <= rpba_pkg::IDX_W'(buf_d);
			status          <= st_d;
			buffer_released <= rel_d;
			packets_in_use  <= rpba_pkg::IDX_W'(pcnt_d);
			buffers_in_use  <= rpba_pkg::IDX_W'(bcnt_d);
		end
	end

	// Every descriptor is either on the free stack or counted as in use.
	a_pkt_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		((PW+1)'(pcnt_q) + (PW+1)'(ptop_q)) == (PW+1)'(NUM_PACKETS))
		else $error("packet count and free stack depth disagree");

	// Every buffer is either on the free stack or counted as in use.
	a_buf_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		((BW+1)'(bcnt_q) + (BW+1)'(btop_q)) == (BW+1)'(NUM_BUFFERS))
		else $error("buffer count and free stack depth disagree");

	// The low-water marks never sit above the stack tops.
	a_low_water: assert property (@(posedge clk) disable iff (!arst_n)
		(pmin_q <= ptop_q) && (bmin_q <= btop_q))
		else $error("free stack low-water mark above top");

	// A new result word only appears out of the write-back stage.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == rpba_pkg::FSM_WRITE))
		else $error("result word raised outside write-back");

endmodule
